/* hw/rtl/cbr_pkg.sv */
// shared constants, types and helpers for the convolution accumulator block
// no dependencies; used by the interfaces and every module of the block
package cbr_pkg;

  localparam int POSITIONS  = 6;
  localparam int CHANNELS   = 16;
  localparam int ACC_DEPTH  = POSITIONS * CHANNELS;
  localparam int IDX_W      = $clog2(ACC_DEPTH);

  localparam int POS_W      = 3;
  localparam int CH_W       = 4;
  localparam int ACT_W      = 16;
  localparam int PROD_W     = 2 * ACT_W;
  localparam int ACC_W      = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  // 6.0 in Q32.16
  localparam logic signed [ACC_W-1:0] SIX_Q16 = ACC_W'(48'h6_0000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED_FROM_BIAS   = 2'd0,
    CFG_ADD_BIAS_ON_INIT = 2'd1,
    CFG_ACTIVATION_KIND  = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_RELU  = 2'd1,
    ACT_RELU6 = 2'd2
  } act_kind_e;

  typedef enum logic {
    MODE_INIT = 1'b0,
    MODE_MAC  = 1'b1
  } mode_e;

  typedef struct packed {
    logic       seed_from_bias;
    logic       add_bias_on_init;
    logic [1:0] activation_kind;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic [CH_W-1:0]         ch;
    logic signed [ACC_W-1:0] value;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } fifo_status_t;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] sum;
    sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      return sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return sum[ACC_W-1:0];
  endfunction

endpackage

/* hw/rtl/cbr_if.sv */
// valid/ready channel interfaces for input items and result words
// depends on cbr_pkg for field widths
interface cbr_in_if
  import cbr_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [POS_W-1:0]        position;
  logic [CH_W-1:0]         channel;
  logic signed [ACT_W-1:0] activation;
  logic signed [ACT_W-1:0] weight;
  logic signed [ACC_W-1:0] partial_sum;
  logic signed [ACC_W-1:0] bias;
  logic                    last_term;

  modport source (
    output valid, mode, position, channel, activation, weight, partial_sum, bias,
           last_term,
    input  ready
  );
  modport sink (
    input  valid, mode, position, channel, activation, weight, partial_sum, bias,
           last_term,
    output ready
  );
endinterface

interface cbr_out_if
  import cbr_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [POS_W-1:0]        out_position;
  logic [CH_W-1:0]         out_channel;
  logic signed [ACC_W-1:0] out_value;

  modport source (
    output valid, out_position, out_channel, out_value,
    input  ready
  );
  modport sink (
    input  valid, out_position, out_channel, out_value,
    output ready
  );
endinterface

/* hw/rtl/conv_accumulate_bias_relu_top.sv */
// top level of the convolution accumulator with bias and relu / relu6
// depends on cbr_pkg, cbr_if, cbr_datapath and cbr_out_fifo
//
// usage:
//   in_i carries one word per item: an init word (mode 0) seeds the accumulator
//   at position/channel from bias or partial_sum, a mac word (mode 1) adds
//   activation * weight with 48-bit saturation. a mac word with last_term set
//   produces one result word on out_o, passed through the selected activation.
//   words addressing a slot outside the array do nothing.
//   configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i while
//   no word is in flight.
// timing:
//   a result word is registered in stage one and then in the output buffer on out_o.
//   one word per cycle is sustained while in_i.ready is high; each in-range word
//   costs one read and one write of the 96-entry accumulator memory, with
//   back-to-back hits on one entry forwarded around the memory read.
//   a two-word output buffer absorbs receiver stalls; in_i.ready drops only
//   when that buffer could overflow.
// reset:
//   clears configuration to zero and empties the pipeline; accumulators hold
//   no value until seeded by an init word.
module conv_accumulate_bias_relu_top
  import cbr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  cbr_in_if.sink                in_i,
  cbr_out_if.source             out_o
);

  cfg_t         cfg_q;
  fifo_status_t fifo_status;
  logic         push;
  result_t      result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SEED_FROM_BIAS:   cfg_q.seed_from_bias   <= cfg_wdata_i[0];
        CFG_ADD_BIAS_ON_INIT: cfg_q.add_bias_on_init <= cfg_wdata_i[0];
        CFG_ACTIVATION_KIND:  cfg_q.activation_kind  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  cbr_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_i     (in_i),
    .fifo_i   (fifo_status),
    .push_o   (push),
    .result_o (result)
  );

  cbr_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .result_i (result),
    .out_o    (out_o),
    .status_o (fifo_status)
  );

endmodule

/* hw/rtl/cbr_datapath.sv */
// accumulator memory with read-modify-write pipeline, bias seeding and activation
// depends on cbr_pkg and cbr_in_if
module cbr_datapath
  import cbr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  cbr_in_if.sink       in_i,
  input  fifo_status_t fifo_i,
  output logic         push_o,
  output result_t      result_o
);

  logic [ACC_W-1:0] mem_q [ACC_DEPTH];

  logic                     accept;
  logic                     in_range;
  logic [IDX_W-1:0]         in_idx;
  logic signed [ACC_W-1:0]  seed;
  logic signed [ACC_W-1:0]  init_d;
  logic signed [PROD_W-1:0] prod_d;
  logic [2:0]               occupancy;

  logic                     s1_valid_q;
  logic                     s1_mode_q;
  logic                     s1_last_q;
  logic [IDX_W-1:0]         s1_idx_q;
  logic [POS_W-1:0]         s1_pos_q;
  logic [CH_W-1:0]          s1_ch_q;
  logic signed [PROD_W-1:0] s1_prod_q;
  logic signed [ACC_W-1:0]  s1_init_q;
  logic                     hit_q;
  logic signed [ACC_W-1:0]  fwd_q;
  logic signed [ACC_W-1:0]  rdata_q;

  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  mac;
  logic signed [ACC_W-1:0]  wr_data;
  logic signed [ACC_W-1:0]  activated;
  logic                     emit;

  // words in flight toward the output buffer must fit its two slots
  assign emit      = s1_valid_q && (s1_mode_q == MODE_MAC) && s1_last_q;
  assign occupancy = 3'(fifo_i.count) + 3'(emit) - 3'(fifo_i.pop);
  assign in_i.ready = (occupancy < 3'd2);
  assign accept    = in_i.valid && in_i.ready;

  assign in_range = (in_i.position < POS_W'(POSITIONS)) &&
                    ({1'b0, in_i.channel} < (CH_W+1)'(CHANNELS));
  assign in_idx   = IDX_W'(IDX_W'(in_i.position) * IDX_W'(CHANNELS) + IDX_W'(in_i.channel));

  always_comb begin
    seed   = cfg_i.seed_from_bias ? in_i.bias : in_i.partial_sum;
    init_d = cfg_i.add_bias_on_init ? sat_add(seed, in_i.bias) : seed;
    prod_d = in_i.activation * in_i.weight;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      s1_valid_q <= accept && in_range;
      // same entry written by the word in stage one at this edge
      hit_q      <= accept && s1_valid_q && (s1_idx_q == in_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= in_i.mode;
      s1_last_q <= in_i.last_term;
      s1_idx_q  <= in_idx;
      s1_pos_q  <= in_i.position;
      s1_ch_q   <= in_i.channel;
      s1_prod_q <= prod_d;
      s1_init_q <= init_d;
    end
    fwd_q <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_range) begin
      rdata_q <= mem_q[in_idx];
    end
    if (s1_valid_q) begin
      mem_q[s1_idx_q] <= wr_data;
    end
  end

  always_comb begin
    base    = hit_q ? fwd_q : rdata_q;
    mac     = sat_add(base, ACC_W'(s1_prod_q));
    wr_data = (s1_mode_q == MODE_MAC) ? mac : s1_init_q;
  end

  // kind three behaves as the clamp to six
  always_comb begin
    activated = mac;
    case (cfg_i.activation_kind)
      ACT_NONE: begin
        activated = mac;
      end
      ACT_RELU: begin
        if (mac < 0) activated = '0;
      end
      default: begin
        if (mac < 0) begin
          activated = '0;
        end else if (mac > SIX_Q16) begin
          activated = SIX_Q16;
        end
      end
    endcase
  end

  assign push_o         = emit;
  assign result_o.pos   = s1_pos_q;
  assign result_o.ch    = s1_ch_q;
  assign result_o.value = activated;

endmodule

/* hw/rtl/cbr_out_fifo.sv */
// two-entry output buffer that decouples the pipeline from the result receiver
// depends on cbr_pkg and cbr_out_if
module cbr_out_fifo
  import cbr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  result_t       result_i,
  cbr_out_if.source     out_o,
  output fifo_status_t  status_o
);

  result_t    entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic [1:0] count_d;
  logic       pop;

  assign pop = out_o.valid && out_o.ready;

  always_comb begin
    count_d = count_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= result_i;
    end
  end

  assign out_o.valid        = (count_q != 2'd0);
  assign out_o.out_position = entry_q[rd_ptr_q].pos;
  assign out_o.out_channel  = entry_q[rd_ptr_q].ch;
  assign out_o.out_value    = entry_q[rd_ptr_q].value;

  assign status_o.count = count_q;
  assign status_o.pop   = pop;

endmodule

/* bench/testbench.sv */
// self-checking bench for conv_accumulate_bias_relu_top: directed table, then random bursts
// depends on cbr_pkg, cbr_in_if / cbr_out_if and the top level of the block
`timescale 1ns / 1ps

module testbench;
  import cbr_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 8;
  localparam int CHUNK_WORDS  = 125;
  localparam int CHUNKS       = 4;

  typedef struct {
    mode_e                   mode;
    logic [POS_W-1:0]        position;
    logic [CH_W-1:0]         channel;
    logic signed [ACT_W-1:0] activation;
    logic signed [ACT_W-1:0] weight;
    logic signed [ACC_W-1:0] partial_sum;
    logic signed [ACC_W-1:0] bias;
    logic                    last_term;
  } in_word_t;

  typedef enum logic { ROW_WORD, ROW_CFG } row_kind_e;

  typedef struct {
    row_kind_e               kind;
    in_word_t                w;
    cfg_t                    cfg;
    bit                      typed;
    logic signed [ACC_W-1:0] value;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cbr_in_if  in_if ();
  cbr_out_if out_if ();

  conv_accumulate_bias_relu_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // own copy of the accumulator file and the registers
  logic signed [ACC_W-1:0] acc_model [ACC_DEPTH];
  bit                      slot_live [ACC_DEPTH];
  cfg_t                    cfg_now;
  result_t                 pending_results [$];
  dir_row_t                dir_tab [$];

  int  send_idle;
  int  recv_idle;
  bit  hold_req;
  int  err_cnt;
  int  results_seen;
  int  init_cnt;
  int  mac_cnt;
  int  oob_cnt;
  int  settings_cnt;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [ACC_W-1:0] clip48(input longint v);
    if (v > longint'(ACC_MAX)) return ACC_MAX;
    if (v < longint'(ACC_MIN)) return ACC_MIN;
    return ACC_W'(v);
  endfunction

  // updates the accumulator copy; returns 1 when the word emits a result
  function automatic bit step_accumulators(input in_word_t w, output result_t r);
    int                      idx;
    logic signed [ACC_W-1:0] seed;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] v;
    r = '0;
    if (w.position >= POSITIONS || w.channel >= CHANNELS) return 1'b0;
    idx = w.position * CHANNELS + w.channel;
    if (w.mode == MODE_INIT) begin
      seed = cfg_now.seed_from_bias ? w.bias : w.partial_sum;
      if (cfg_now.add_bias_on_init) seed = clip48(longint'(seed) + longint'(w.bias));
      acc_model[idx] = seed;
      slot_live[idx] = 1'b1;
      return 1'b0;
    end
    sum = clip48(longint'(acc_model[idx]) + longint'(w.activation) * longint'(w.weight));
    acc_model[idx] = sum;
    if (!w.last_term) return 1'b0;
    v = sum;
    if (cfg_now.activation_kind != ACT_NONE && v < 0) v = '0;
    if (cfg_now.activation_kind[1] && v > SIX_Q16) v = SIX_Q16;
    r.pos   = w.position;
    r.ch    = w.channel;
    r.value = v;
    return 1'b1;
  endfunction

  function automatic logic signed [ACT_W-1:0] rand_q8();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return ACT_W'(int'($urandom_range(0, 1023)) - 512);
      default: return ACT_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [ACC_W-1:0] rand_q16();
    int t;
    t = $urandom_range(0, 'h100000);
    case ($urandom_range(9))
      0:       return ACC_MAX;
      1:       return ACC_MIN;
      2, 3:    return ACC_W'({$urandom, $urandom});
      4, 5, 6: return ACC_W'(longint'(t) - longint'('h80000));
      default: return ACC_W'(longint'(int'($urandom)));
    endcase
  endfunction

  function automatic in_word_t fresh_word(input mode_e m, input int p, input int c,
                                          input bit last);
    in_word_t w;
    w.mode        = m;
    w.position    = POS_W'(p);
    w.channel     = CH_W'(c);
    w.activation  = rand_q8();
    w.weight      = rand_q8();
    w.partial_sum = rand_q16();
    w.bias        = rand_q16();
    w.last_term   = last;
    return w;
  endfunction

  // a word aimed outside the position range
  function automatic in_word_t stray_word();
    return fresh_word(mode_e'($urandom_range(1)), $urandom_range(POSITIONS, 7),
                      $urandom_range(15), $urandom_range(1));
  endfunction

  function automatic dir_row_t mk_word(input mode_e m, input int p, input int c,
                                       input logic signed [ACT_W-1:0] a,
                                       input logic signed [ACT_W-1:0] wt,
                                       input logic signed [ACC_W-1:0] ps,
                                       input logic signed [ACC_W-1:0] b,
                                       input bit last, input bit typed = 1'b0,
                                       input logic signed [ACC_W-1:0] v = '0);
    dir_row_t row;
    row.kind          = ROW_WORD;
    row.cfg           = '0;
    row.w.mode        = m;
    row.w.position    = POS_W'(p);
    row.w.channel     = CH_W'(c);
    row.w.activation  = a;
    row.w.weight      = wt;
    row.w.partial_sum = ps;
    row.w.bias        = b;
    row.w.last_term   = last;
    row.typed         = typed;
    row.value         = v;
    return row;
  endfunction

  function automatic dir_row_t mk_cfg(input logic seed, input logic addb,
                                      input logic [1:0] kind);
    dir_row_t row;
    row = mk_word(MODE_INIT, 0, 0, 0, 0, 0, 0, 1'b0);
    row.kind                 = ROW_CFG;
    row.cfg.seed_from_bias   = seed;
    row.cfg.add_bias_on_init = addb;
    row.cfg.activation_kind  = kind;
    return row;
  endfunction

  // offer one word, wait for the handshake, then record what it should produce
  task automatic send_word(input in_word_t w, input bit typed = 1'b0,
                           input logic signed [ACC_W-1:0] typed_value = '0);
    result_t r;
    bit      emits;
    in_if.valid       <= 1'b1;
    in_if.mode        <= w.mode;
    in_if.position    <= w.position;
    in_if.channel     <= w.channel;
    in_if.activation  <= w.activation;
    in_if.weight      <= w.weight;
    in_if.partial_sum <= w.partial_sum;
    in_if.bias        <= w.bias;
    in_if.last_term   <= w.last_term;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    emits = step_accumulators(w, r);
    if (typed) begin
      r.pos   = w.position;
      r.ch    = w.channel;
      r.value = typed_value;
      emits   = 1'b1;
    end
    if (emits) pending_results.push_back(r);
    if (w.position >= POSITIONS || w.channel >= CHANNELS) oob_cnt++;
    else if (w.mode == MODE_INIT) init_cnt++;
    else mac_cnt++;
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop offering and let every pending result drain
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic load_cfg(input logic seed, input logic addb, input logic [1:0] kind);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SEED_FROM_BIAS;
    cfg_wdata <= {1'b0, seed};
    @(posedge clk);
    cfg_index <= CFG_ADD_BIAS_ON_INIT;
    cfg_wdata <= {1'b0, addb};
    @(posedge clk);
    cfg_index <= CFG_ACTIVATION_KIND;
    cfg_wdata <= kind;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_now.seed_from_bias   = seed;
    cfg_now.add_bias_on_init = addb;
    cfg_now.activation_kind  = kind;
    settings_cnt++;
  endtask

  // mostly init + round-robin mac chains over up to three slots, some noise
  task automatic run_burst();
    int n_slots;
    int n_rounds;
    int p;
    int c;
    int pos_l [3];
    int ch_l [3];
    if ($urandom_range(99) < 80) begin
      n_slots  = $urandom_range(1, 3);
      n_rounds = $urandom_range(1, 6);
      for (int s = 0; s < n_slots; s++) begin
        pos_l[s] = $urandom_range(0, POSITIONS - 1);
        ch_l[s]  = $urandom_range(0, CHANNELS - 1);
        send_word(fresh_word(MODE_INIT, pos_l[s], ch_l[s], $urandom_range(7) == 0));
      end
      for (int rnd = 1; rnd <= n_rounds; rnd++) begin
        for (int s = 0; s < n_slots; s++) begin
          if ($urandom_range(99) < 4) send_word(stray_word());
          send_word(fresh_word(MODE_MAC, pos_l[s], ch_l[s], rnd == n_rounds));
        end
      end
    end else begin
      repeat ($urandom_range(2, 5)) begin
        p = $urandom_range(0, POSITIONS - 1);
        c = $urandom_range(0, CHANNELS - 1);
        case ($urandom_range(2))
          0: send_word(stray_word());
          1: begin
            if (slot_live[p * CHANNELS + c])
              send_word(fresh_word(MODE_MAC, p, c, $urandom_range(1)));
            else
              send_word(fresh_word(MODE_INIT, p, c, $urandom_range(1)));
          end
          default: send_word(fresh_word(MODE_INIT, p, c, $urandom_range(1)));
        endcase
      end
    end
  endtask

  // receiver side: random stalls, one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: got pos %0d ch %0d value %h", $time,
                 out_if.out_position, out_if.out_channel, out_if.out_value);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (out_if.out_position !== want.pos || out_if.out_channel !== want.ch ||
            out_if.out_value !== want.value) begin
          $display("%0t: result mismatch: expected pos %0d ch %0d value %h, got pos %0d ch %0d value %h",
                   $time, want.pos, want.ch, want.value,
                   out_if.out_position, out_if.out_channel, out_if.out_value);
          err_cnt++;
        end
      end
    end
  end

  // no word moving on either side for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int target;
    int k;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_SEED_FROM_BIAS;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.mode        = MODE_INIT;
    in_if.position    = '0;
    in_if.channel     = '0;
    in_if.activation  = '0;
    in_if.weight      = '0;
    in_if.partial_sum = '0;
    in_if.bias        = '0;
    in_if.last_term   = 1'b0;
    cfg_now           = '0;
    send_idle         = 0;
    recv_idle         = 0;
    hold_req          = 1'b0;
    err_cnt           = 0;
    results_seen      = 0;
    init_cnt          = 0;
    mac_cnt           = 0;
    oob_cnt           = 0;
    settings_cnt      = 0;
    quiet_cycles      = 0;

    // registers start at zero: seed from partial sum, no bias add, no activation
    dir_tab.push_back(mk_word(MODE_INIT, 0, 0, 0, 0, 0, 48'sh1234, 1'b0));
    dir_tab.push_back(mk_word(MODE_MAC, 0, 0, 16'sh7FFF, 16'sh7FFF, 0, 0, 1'b1,
                              1'b1, 48'sh3FFF_0001));
    dir_tab.push_back(mk_word(MODE_INIT, 5, 15, 0, 0, ACC_MAX, ACC_MIN, 1'b0));
    dir_tab.push_back(mk_word(MODE_MAC, 5, 15, 16'sh7FFF, 16'sh7FFF, 0, 0, 1'b1,
                              1'b1, ACC_MAX));
    dir_tab.push_back(mk_word(MODE_INIT, 5, 0, 0, 0, ACC_MIN, ACC_MAX, 1'b0));
    dir_tab.push_back(mk_word(MODE_MAC, 5, 0, 16'sh8000, 16'sh7FFF, 0, 0, 1'b1,
                              1'b1, ACC_MIN));
    dir_tab.push_back(mk_word(MODE_MAC, 0, 0, 16'sh8000, 16'sh8000, 0, 0, 1'b0));
    dir_tab.push_back(mk_word(MODE_MAC, 0, 0, 0, 0, 0, 0, 1'b1));
    // last flag on an init word is ignored
    dir_tab.push_back(mk_word(MODE_INIT, 1, 3, 16'sh7FFF, 16'sh8000, -48'sd5, ACC_MAX, 1'b1));
    // slots outside the array do nothing
    dir_tab.push_back(mk_word(MODE_MAC, 6, 0, 16'sh7FFF, 16'sh7FFF, 0, 0, 1'b1));
    dir_tab.push_back(mk_word(MODE_INIT, 7, 15, 0, 0, ACC_MAX, ACC_MAX, 1'b1));
    dir_tab.push_back(mk_word(MODE_MAC, 1, 3, 1, 1, 0, 0, 1'b1, 1'b1, -48'sd4));
    dir_tab.push_back(mk_cfg(1'b1, 1'b0, ACT_NONE));
    dir_tab.push_back(mk_word(MODE_INIT, 2, 7, 0, 0, ACC_MIN, 48'sh1_2345, 1'b0));
    dir_tab.push_back(mk_word(MODE_MAC, 2, 7, 0, 0, 0, 0, 1'b1, 1'b1, 48'sh1_2345));
    // seed from bias plus bias add: doubled bias, saturated
    dir_tab.push_back(mk_cfg(1'b1, 1'b1, ACT_NONE));
    dir_tab.push_back(mk_word(MODE_INIT, 3, 8, 0, 0, 0, ACC_MAX, 1'b0));
    dir_tab.push_back(mk_word(MODE_MAC, 3, 8, 0, 0, 0, 0, 1'b1, 1'b1, ACC_MAX));
    dir_tab.push_back(mk_cfg(1'b0, 1'b1, ACT_NONE));
    dir_tab.push_back(mk_word(MODE_INIT, 4, 9, 0, 0, ACC_MIN, ACC_MIN, 1'b0));
    dir_tab.push_back(mk_word(MODE_MAC, 4, 9, 0, 0, 0, 0, 1'b1, 1'b1, ACC_MIN));
    dir_tab.push_back(mk_cfg(1'b0, 1'b0, ACT_RELU));
    dir_tab.push_back(mk_word(MODE_MAC, 4, 9, 0, 0, 0, 0, 1'b1, 1'b1, '0));
    dir_tab.push_back(mk_word(MODE_MAC, 0, 0, 0, 0, 0, 0, 1'b1));
    dir_tab.push_back(mk_cfg(1'b0, 1'b1, ACT_RELU6));
    dir_tab.push_back(mk_word(MODE_INIT, 0, 1, 0, 0, 48'sh6_0000, 48'sd1, 1'b0));
    dir_tab.push_back(mk_word(MODE_MAC, 0, 1, 0, 0, 0, 0, 1'b1, 1'b1, SIX_Q16));
    dir_tab.push_back(mk_word(MODE_MAC, 0, 1, -16'sd2, 16'sd1, 0, 0, 1'b1));
    // kind three behaves as relu6
    dir_tab.push_back(mk_cfg(1'b0, 1'b0, 2'd3));
    dir_tab.push_back(mk_word(MODE_MAC, 3, 8, 0, 0, 0, 0, 1'b1, 1'b1, SIX_Q16));
    dir_tab.push_back(mk_word(MODE_MAC, 5, 0, 0, 0, 0, 0, 1'b1, 1'b1, '0));
    // the clamp only touched the output, the accumulator still holds the maximum
    dir_tab.push_back(mk_cfg(1'b0, 1'b0, ACT_NONE));
    dir_tab.push_back(mk_word(MODE_MAC, 3, 8, 0, 0, 0, 0, 1'b1, 1'b1, ACC_MAX));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG)
        load_cfg(dir_tab[i].cfg.seed_from_bias, dir_tab[i].cfg.add_bias_on_init,
                 dir_tab[i].cfg.activation_kind);
      else
        send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].value);
    end

    for (int ph = 0; ph < 3; ph++) begin
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
        k = ph * CHUNKS + chunk;
        case (k)
          0:       load_cfg(1'b1, 1'b1, ACT_RELU6);
          1:       load_cfg(1'b0, 1'b0, ACT_NONE);
          2:       load_cfg(1'b1, 1'b0, ACT_RELU);
          3:       load_cfg(1'b0, 1'b1, 2'd3);
          default: load_cfg($urandom_range(1), $urandom_range(1), $urandom_range(3));
        endcase
        case (ph)
          0: begin
            send_idle = 37;
            recv_idle = 67;
          end
          1: begin
            send_idle = 67;
            recv_idle = 37;
          end
          default: begin
            send_idle = 0;
            recv_idle = 0;
          end
        endcase
        // fill the block while the receiver holds off
        if (ph == 2 && chunk == 0) hold_req = 1'b1;
        target = init_cnt + mac_cnt + CHUNK_WORDS;
        while (init_cnt + mac_cnt < target) run_burst();
      end
    end

    settle();
    $display("covered %0d words: %0d init, %0d mac, %0d outside the array; %0d results checked",
             init_cnt + mac_cnt + oob_cnt, init_cnt, mac_cnt, oob_cnt, results_seen);
    $display("walked %0d register settings, with a %0d-cycle receiver hold-off",
             settings_cnt, HOLD_CYCLES);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cbr_pkg.sv
hw/rtl/cbr_if.sv
hw/rtl/cbr_datapath.sv
hw/rtl/cbr_out_fifo.sv
hw/rtl/conv_accumulate_bias_relu_top.sv
bench/testbench.sv
